### rtl/sme_pkg.sv
// Shared types and constants for the SPI master word engine.
// No dependencies; every other file refers to this package by scoped names.
package sme_pkg;

    // Engine phase
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_SHIFT = 2'd1,
        PH_WAIT  = 2'd2,
        PH_CLOSE = 2'd3
    } t_phase;

    // What one queued item asks of the engine
    typedef enum logic [1:0] {
        K_TICK = 2'd0,   // clock tick only, no word offered
        K_WORD = 2'd1,   // word offered, more follow in this transfer
        K_LAST = 2'd2    // word offered, last of its transfer
    } t_kind;

    // Configuration register indexes (byte address = 4 * index)
    typedef enum logic [2:0] {
        REG_DIVIDER   = 3'd0,
        REG_WORD_LEN  = 3'd1,
        REG_CPOL      = 3'd2,
        REG_CPHA      = 3'd3,
        REG_LSB_FIRST = 3'd4,
        REG_SEL_HIGH  = 3'd5,
        REG_SEL_INDEX = 3'd6,
        REG_SEL_HOLD  = 3'd7
    } t_reg_idx;

    localparam int CFG_DIV_W     = 10;
    localparam int CFG_LEN_W     = 5;
    localparam int TX_WORD_W     = 32;
    localparam int RX_WORD_W     = 32;
    localparam int APB_ADDR_W    = 5;
    localparam int APB_DATA_W    = 32;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 40;
    // Queue depth, a power of two so the pointers wrap on their own
    localparam int QUEUE_DEPTH   = 2;

    typedef struct packed {
        logic [CFG_DIV_W-1:0] divider;
        logic [CFG_LEN_W-1:0] word_len_m1;
        logic                 cpol;
        logic                 cpha;
        logic                 lsb_first;
        logic                 sel_high;
        logic                 sel_index;
        logic                 sel_hold;
    } t_cfg;

    // One classified tick travelling from front to back
    typedef struct packed {
        t_kind                kind;
        logic [TX_WORD_W-1:0] tx_word;
        logic                 miso;
    } t_item;

    // One result item
    typedef struct packed {
        logic                 sclk;
        logic                 mosi;
        logic [1:0]           select_lines;
        logic                 rx_valid;
        logic [RX_WORD_W-1:0] rx_word;
        logic                 ready_res;
    } t_result;

endpackage

### rtl/sme_front.sv
// Front end: takes stream items, unpacks them and classifies the offer.
// Depends on sme_pkg; feeds sme_fifo.
module sme_front (
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [sme_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,
    input  logic                               i_q_ready,
    output logic                               o_push,
    output sme_pkg::t_item                     o_item
);

    // Accept whenever the queue has room
    assign s_axis_tready = i_q_ready;
    assign o_push        = s_axis_tvalid & i_q_ready;

    // tdata: bit 0 tx_valid, bits 32:1 tx_word, bit 33 miso
    always_comb begin
        o_item.tx_word = s_axis_tdata[sme_pkg::TX_WORD_W:1];
        o_item.miso    = s_axis_tdata[sme_pkg::TX_WORD_W+1];
        if (!s_axis_tdata[0]) begin
            o_item.kind = sme_pkg::K_TICK;
        end else if (s_axis_tlast) begin
            o_item.kind = sme_pkg::K_LAST;
        end else begin
            o_item.kind = sme_pkg::K_WORD;
        end
    end

endmodule

### rtl/sme_fifo.sv
// Short item queue between the front end and the shift engine.
// Depends on sme_pkg for the item type and depth.
module sme_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sme_pkg::t_item  i_item,
    output logic            o_ready,
    output logic            o_valid,
    output sme_pkg::t_item  o_item,
    input  logic            i_pop
);

    localparam int PW = $clog2(sme_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(sme_pkg::QUEUE_DEPTH + 1);

    sme_pkg::t_item r_mem [sme_pkg::QUEUE_DEPTH];
    logic [PW-1:0]  r_wptr, r_rptr;
    logic [CW-1:0]  r_count;
    logic           w_do_push, w_do_pop;

    assign o_ready   = (r_count != CW'(sme_pkg::QUEUE_DEPTH));
    assign o_valid   = (r_count != '0);
    assign o_item    = r_mem[r_rptr];
    assign w_do_push = i_push & o_ready;
    assign w_do_pop  = i_pop & o_valid;

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (w_do_push) r_wptr <= r_wptr + PW'(1);
            if (w_do_pop)  r_rptr <= r_rptr + PW'(1);
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + CW'(1);
                2'b01:   r_count <= r_count - CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) r_mem[r_wptr] <= i_item;
    end

endmodule

### rtl/sme_back.sv
// Back end: SPI shift engine, one queued tick per step, with a result register.
// Depends on sme_pkg; reads items from sme_fifo.
module sme_back #(
    parameter int MAX_WORD_BITS = 32,
    parameter int DIVIDER_BITS  = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sme_pkg::t_cfg     i_cfg,
    input  logic              i_q_valid,
    input  sme_pkg::t_item    i_q_item,
    output logic              o_q_pop,
    output logic              o_res_valid,
    output sme_pkg::t_result  o_res,
    input  logic              i_res_ready
);

    localparam int BCW = $clog2(MAX_WORD_BITS + 1);
    localparam int IW  = $clog2(MAX_WORD_BITS);
    localparam int MW  = MAX_WORD_BITS;
    localparam int DW  = DIVIDER_BITS;

    sme_pkg::t_phase    r_phase, n_phase;
    logic [DW-1:0]      r_tick, n_tick;
    logic [BCW-1:0]     r_bit, n_bit;
    logic [MW-1:0]      r_tx, n_tx;
    logic [MW-1:0]      r_rx, n_rx;
    logic               r_clk_lvl, n_clk_lvl;
    logic               r_sel_on, n_sel_on;
    logic               r_last, n_last;
    logic               r_out_valid;
    sme_pkg::t_result   r_out, n_out;

    logic [5:0]         w_len;
    logic [BCW-1:0]     w_nbits;
    logic [IW-1:0]      w_top;
    logic [MW-1:0]      w_mask;
    logic [MW-1:0]      w_mi_top;
    logic [DW-1:0]      w_div;
    logic [MW+sme_pkg::TX_WORD_W-1:0] w_tx_ext;
    logic [MW+sme_pkg::RX_WORD_W-1:0] w_rx_ext;
    logic [sme_pkg::CFG_DIV_W+DW-1:0] w_div_ext;
    logic               w_offer, w_edge, w_act, w_inact, w_sel;

    // A step runs when an item is queued and the result slot is free or draining
    assign o_q_pop     = i_q_valid & (~r_out_valid | i_res_ready);
    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

    // Word length, capped at the shift register width
    always_comb begin
        w_len = {1'b0, i_cfg.word_len_m1} + 6'd1;
        if (int'(w_len) > MW) begin
            w_nbits = BCW'(MW);
        end else begin
            w_nbits = BCW'(w_len);
        end
        w_top = IW'(w_nbits - BCW'(1));
        for (int i = 0; i < MW; i++) begin
            w_mask[i] = (i < int'(w_nbits));
        end
        w_mi_top  = {{(MW-1){1'b0}}, i_q_item.miso} << w_top;
        w_tx_ext  = {{MW{1'b0}}, i_q_item.tx_word};
        w_div_ext = {{DW{1'b0}}, i_cfg.divider};
        w_div     = w_div_ext[DW-1:0];
    end

    // Next state and result of one tick
    always_comb begin
        n_phase   = r_phase;
        n_tick    = r_tick;
        n_bit     = r_bit;
        n_tx      = r_tx;
        n_rx      = r_rx;
        n_clk_lvl = r_clk_lvl;
        n_sel_on  = r_sel_on;
        n_last    = r_last;
        w_offer   = (i_q_item.kind == sme_pkg::K_WORD) || (i_q_item.kind == sme_pkg::K_LAST);
        w_edge    = (r_tick >= w_div);
        n_out.rx_valid = 1'b0;
        n_out.rx_word  = '0;
        w_rx_ext       = '0;

        case (r_phase)
            sme_pkg::PH_IDLE, sme_pkg::PH_WAIT: begin
                if (w_offer) begin
                    n_tx      = w_tx_ext[MW-1:0] & w_mask;
                    n_rx      = '0;
                    n_bit     = '0;
                    n_tick    = '0;
                    n_clk_lvl = 1'b0;
                    n_last    = (i_q_item.kind == sme_pkg::K_LAST);
                    n_sel_on  = 1'b1;
                    n_phase   = sme_pkg::PH_SHIFT;
                end
            end
            sme_pkg::PH_SHIFT: begin
                if (w_edge) begin
                    n_tick = '0;
                    if (!r_clk_lvl) begin
                        // leading edge
                        n_clk_lvl = 1'b1;
                        if (!i_cfg.cpha) begin
                            n_rx = i_cfg.lsb_first ? ((r_rx >> 1) | w_mi_top)
                                                   : {r_rx[MW-2:0], i_q_item.miso};
                        end else if (r_bit != '0) begin
                            n_tx = i_cfg.lsb_first ? (r_tx >> 1) : (r_tx << 1);
                        end
                    end else begin
                        // trailing edge
                        n_clk_lvl = 1'b0;
                        if (i_cfg.cpha) begin
                            n_rx = i_cfg.lsb_first ? ((r_rx >> 1) | w_mi_top)
                                                   : {r_rx[MW-2:0], i_q_item.miso};
                        end
                        n_bit = r_bit + BCW'(1);
                        if (!i_cfg.cpha) begin
                            n_tx = i_cfg.lsb_first ? (r_tx >> 1) : (r_tx << 1);
                        end
                        if (n_bit >= w_nbits) begin
                            w_rx_ext       = {{sme_pkg::RX_WORD_W{1'b0}}, n_rx & w_mask};
                            n_out.rx_valid = 1'b1;
                            n_out.rx_word  = w_rx_ext[sme_pkg::RX_WORD_W-1:0];
                            n_phase = r_last ? sme_pkg::PH_CLOSE : sme_pkg::PH_WAIT;
                        end
                    end
                end else begin
                    n_tick = r_tick + DW'(1);
                end
            end
            default: begin
                // closing half period, then select release unless sel_hold is set
                if (w_edge) begin
                    n_tick = '0;
                    if (!i_cfg.sel_hold) n_sel_on = 1'b0;
                    n_phase = sme_pkg::PH_IDLE;
                end else begin
                    n_tick = r_tick + DW'(1);
                end
            end
        endcase

        // Pin levels after this tick
        w_act   = i_cfg.sel_high;
        w_inact = ~i_cfg.sel_high;
        w_sel   = n_sel_on ? w_act : w_inact;
        n_out.sclk = i_cfg.cpol ^ n_clk_lvl;
        if (n_phase == sme_pkg::PH_SHIFT) begin
            n_out.mosi = i_cfg.lsb_first ? n_tx[0] : n_tx[w_top];
        end else begin
            n_out.mosi = 1'b0;
        end
        n_out.select_lines = i_cfg.sel_index ? {w_sel, w_inact} : {w_inact, w_sel};
        n_out.ready_res    = (n_phase == sme_pkg::PH_IDLE) || (n_phase == sme_pkg::PH_WAIT);
    end

    // Engine state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= sme_pkg::PH_IDLE;
            r_tick    <= '0;
            r_bit     <= '0;
            r_tx      <= '0;
            r_rx      <= '0;
            r_clk_lvl <= 1'b0;
            r_sel_on  <= 1'b0;
            r_last    <= 1'b0;
        end else if (o_q_pop) begin
            r_phase   <= n_phase;
            r_tick    <= n_tick;
            r_bit     <= n_bit;
            r_tx      <= n_tx;
            r_rx      <= n_rx;
            r_clk_lvl <= n_clk_lvl;
            r_sel_on  <= n_sel_on;
            r_last    <= n_last;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_q_pop) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) r_out <= n_out;
    end

endmodule

### rtl/spi_master_word_engine.sv
// Top level of the SPI master word engine: APB registers, front end, queue, engine.
// Depends on sme_pkg, sme_front, sme_fifo and sme_back.
//
// Each input item is one system clock tick of the SPI engine (optional word to
// send, sampled MISO level) and yields exactly one result item (SCK, MOSI, both
// select levels, a received word when one completes, ready for the next word).
// Sustained rate is one item per clock cycle while the output is not stalled. An
// accepted item waits in a two-entry queue; the engine step in sme_back then
// writes its result into a one-entry result register, from which it is presented.
// SCK half period is clock_divider+1 items.
// Write the registers only while no item is in flight.
module spi_master_word_engine #(
    parameter int MAX_WORD_BITS = 32,
    parameter int DIVIDER_BITS  = 10
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input items
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] tx_valid, [32:1] tx_word, [33] miso, [39:34] zero
    input  logic [sme_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                               s_axis_tlast,   // tx_last
    // Result items
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] sclk, [1] mosi, [3:2] select_lines, [4] rx_valid, [36:5] rx_word,
    // [37] ready_res, [39:38] zero
    output logic [sme_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // Configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [sme_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [sme_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [sme_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    sme_pkg::t_cfg     r_cfg;
    sme_pkg::t_reg_idx w_idx;
    logic              w_wr;
    logic              w_push, w_q_ready, w_q_valid, w_pop;
    sme_pkg::t_item    w_in_item, w_q_item;
    sme_pkg::t_result  w_res;

    // Register file
    assign pready = 1'b1;
    assign w_idx  = sme_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{divider: '0, word_len_m1: sme_pkg::CFG_LEN_W'(7), cpol: 1'b0,
                       cpha: 1'b0, lsb_first: 1'b0, sel_high: 1'b0, sel_index: 1'b0,
                       sel_hold: 1'b0};
        end else if (w_wr) begin
            case (w_idx)
                sme_pkg::REG_DIVIDER:   r_cfg.divider     <= pwdata[sme_pkg::CFG_DIV_W-1:0];
                sme_pkg::REG_WORD_LEN:  r_cfg.word_len_m1 <= pwdata[sme_pkg::CFG_LEN_W-1:0];
                sme_pkg::REG_CPOL:      r_cfg.cpol        <= pwdata[0];
                sme_pkg::REG_CPHA:      r_cfg.cpha        <= pwdata[0];
                sme_pkg::REG_LSB_FIRST: r_cfg.lsb_first   <= pwdata[0];
                sme_pkg::REG_SEL_HIGH:  r_cfg.sel_high    <= pwdata[0];
                sme_pkg::REG_SEL_INDEX: r_cfg.sel_index   <= pwdata[0];
                sme_pkg::REG_SEL_HOLD:  r_cfg.sel_hold    <= pwdata[0];
                default:                r_cfg             <= r_cfg;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (w_idx)
            sme_pkg::REG_DIVIDER:   prdata = {{(sme_pkg::APB_DATA_W-sme_pkg::CFG_DIV_W){1'b0}},
                                              r_cfg.divider};
            sme_pkg::REG_WORD_LEN:  prdata = {{(sme_pkg::APB_DATA_W-sme_pkg::CFG_LEN_W){1'b0}},
                                              r_cfg.word_len_m1};
            sme_pkg::REG_CPOL:      prdata = {31'd0, r_cfg.cpol};
            sme_pkg::REG_CPHA:      prdata = {31'd0, r_cfg.cpha};
            sme_pkg::REG_LSB_FIRST: prdata = {31'd0, r_cfg.lsb_first};
            sme_pkg::REG_SEL_HIGH:  prdata = {31'd0, r_cfg.sel_high};
            sme_pkg::REG_SEL_INDEX: prdata = {31'd0, r_cfg.sel_index};
            sme_pkg::REG_SEL_HOLD:  prdata = {31'd0, r_cfg.sel_hold};
            default:                prdata = '0;
        endcase
    end

    sme_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .i_q_ready     (w_q_ready),
        .o_push        (w_push),
        .o_item        (w_in_item)
    );

    sme_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_ready (w_q_ready),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .i_pop   (w_pop)
    );

    sme_back #(
        .MAX_WORD_BITS (MAX_WORD_BITS),
        .DIVIDER_BITS  (DIVIDER_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (w_q_valid),
        .i_q_item    (w_q_item),
        .o_q_pop     (w_pop),
        .o_res_valid (m_axis_tvalid),
        .o_res       (w_res),
        .i_res_ready (m_axis_tready)
    );

    // Result packing
    assign m_axis_tdata = {2'b00, w_res.ready_res, w_res.rx_word, w_res.rx_valid,
                           w_res.select_lines, w_res.mosi, w_res.sclk};

    // A full queue always has an item for the engine
    a_full_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> w_q_valid)
        else $error("queue reports full with nothing to pop");

    // A result is only withdrawn after it was taken
    a_result_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(m_axis_tvalid) |-> $past(m_axis_tready))
        else $error("result dropped without handshake");

    // The engine steps only when the result slot can take its output
    a_step_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && m_axis_tvalid) |-> m_axis_tready)
        else $error("engine stepped over a pending result");

endmodule
